/* hw/rtl/rcbt_pkg.sv */
// shared constants and codes of the relay channel binding table
package rcbt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int OFF_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 64;
    localparam int PORT_W        = 16;
    localparam int CHAN_W        = 15;
    localparam int CHAN_OFF_W    = CHAN_W - 1;
    localparam int PEER_W        = 2 * ADDR_W + PORT_W;
    localparam int DATA_W        = 160;
    localparam int USER_W        = 3;

    typedef enum logic [2:0] {
        ACT_BIND      = 3'd0,
        ACT_ACTIVATE  = 3'd1,
        ACT_UNBIND    = 3'd2,
        ACT_DROP_ADDR = 3'd3,
        ACT_FIND_NUM  = 3'd4,
        ACT_FIND_PEER = 3'd5,
        ACT_CLEAR     = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_ALREADY = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_NO_PERM = 3'd3,
        STAT_MISS    = 3'd4
    } status_t;

endpackage

/* hw/rtl/rcbt_ram.sv */
// generic single write port ram with registered read
module rcbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/relay_channel_binding_table_top.sv */
// relay channel binding table: peer bindings with channel numbers in rams
// lookups and bind make one ram walk over all entries
// unbind and drop address add a rank rebuild that visits every remaining entry
// and every empty rank; clear skips the walk
// one item at a time; the next item is taken while the result still waits on the output
// reset clears the entry flags, the number bitmap and the count; ram contents stay undefined
module relay_channel_binding_table_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // peer_addr_high, peer_addr_low, peer_port, channel_number, permitted
    input  logic [rcbt_pkg::DATA_W-1:0] s_tdata,
    // action
    input  logic [rcbt_pkg::USER_W-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // found_channel, found_addr_high, found_addr_low, found_port, found_active
    output logic [rcbt_pkg::DATA_W-1:0] m_tdata,
    // status
    output logic [rcbt_pkg::USER_W-1:0] m_tuser
);

    import rcbt_pkg::*;

    localparam int N = TABLE_ENTRIES;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DECIDE = 7'b0000100,
        ST_R0     = 7'b0001000,
        ST_R1     = 7'b0010000,
        ST_R2     = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // entry flags, held-number bitmap (offset from first number), entry count
    logic [N-1:0]     used_reg;
    logic [N-1:0]     active_reg;
    logic [N:0]       held_reg;
    logic [CNT_W-1:0] count_reg;

    // latched item
    action_t           in_op_reg;
    logic [ADDR_W-1:0] in_hi_reg;
    logic [ADDR_W-1:0] in_lo_reg;
    logic [PORT_W-1:0] in_port_reg;
    logic [CHAN_W-1:0] in_chan_reg;
    logic              in_perm_reg;

    // walk control
    logic [IDX_W-1:0] rd_idx_reg;
    logic             issuing_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    // match capture
    logic              found_reg;
    logic [IDX_W-1:0]  m_slot_reg;
    logic [OFF_W-1:0]  m_off_reg;
    logic              m_act_reg;
    logic [ADDR_W-1:0] m_hi_reg;
    logic [ADDR_W-1:0] m_lo_reg;
    logic [PORT_W-1:0] m_port_reg;

    // removal and rank rebuild
    logic             any_kill_reg;
    logic [CNT_W-1:0] kill_cnt_reg;
    logic [N-1:0]     agebits_reg;
    logic [IDX_W-1:0] o_reg;
    logic [IDX_W-1:0] r_reg;
    logic [IDX_W-1:0] reb_slot_reg;

    // pending result and output register
    status_t           res_status_reg;
    logic [CHAN_W-1:0] res_chan_reg;
    logic [ADDR_W-1:0] res_hi_reg;
    logic [ADDR_W-1:0] res_lo_reg;
    logic [PORT_W-1:0] res_port_reg;
    logic              res_act_reg;
    logic              m_tvalid_reg;
    status_t           out_status_reg;
    logic [CHAN_W-1:0] out_chan_reg;
    logic [ADDR_W-1:0] out_hi_reg;
    logic [ADDR_W-1:0] out_lo_reg;
    logic [PORT_W-1:0] out_port_reg;
    logic              out_act_reg;

    // ram ports
    logic [PEER_W-1:0] a_q;
    logic [OFF_W-1:0]  b_q;
    logic [IDX_W-1:0]  age_q;
    logic [IDX_W-1:0]  rank_q;
    logic              a_we, b_we, age_we, rank_we;
    logic [IDX_W-1:0]  b_waddr, age_waddr, b_raddr;
    logic [IDX_W-1:0]  age_wdata;

    logic [IDX_W-1:0]      free_slot;
    logic [OFF_W-1:0]      free_num;
    logic [CHAN_OFF_W-1:0] q_off;
    logic                  q_ok;
    logic                  peer_hit, addr_hit, num_hit, sel_hit, kill;
    logic                  is_lookup, bind_ins, ren_wr, last_rank;

    function automatic logic [IDX_W-1:0] low_zero_slot(input logic [N-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (!v[k])
            begin
                r = IDX_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [OFF_W-1:0] low_zero_num(input logic [N:0] v);
        logic [OFF_W-1:0] r;
        r = '0;
        for (int k = N; k >= 0; k--)
        begin
            if (!v[k])
            begin
                r = OFF_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] chan_of(input logic [OFF_W-1:0] off);
        return {1'b1, CHAN_OFF_W'(off)};
    endfunction

    assign free_slot = low_zero_slot(used_reg);
    // at most N numbers are ever held, so an offset of N or less is always free
    assign free_num  = low_zero_num(held_reg);

    assign q_off = in_chan_reg[CHAN_OFF_W-1:0];
    assign q_ok  = in_chan_reg[CHAN_W-1] && (q_off <= CHAN_OFF_W'(N));

    // compare stage of the walk, in the cycle after the ram read
    assign peer_hit = used_reg[cmp_idx_reg] && (a_q == {in_port_reg, in_lo_reg, in_hi_reg});
    assign addr_hit = used_reg[cmp_idx_reg] && (a_q[2*ADDR_W-1:0] == {in_lo_reg, in_hi_reg});
    assign num_hit  = used_reg[cmp_idx_reg] && q_ok && (b_q == OFF_W'(q_off));
    assign sel_hit  = (in_op_reg == ACT_FIND_PEER) ? num_hit : peer_hit;
    assign kill     = ((in_op_reg == ACT_UNBIND) && peer_hit)
                   || ((in_op_reg == ACT_DROP_ADDR) && addr_hit);
    assign is_lookup = (in_op_reg == ACT_BIND) || (in_op_reg == ACT_ACTIVATE)
                    || (in_op_reg == ACT_FIND_NUM) || (in_op_reg == ACT_FIND_PEER);

    assign bind_ins = (state_reg == ST_DECIDE) && (in_op_reg == ACT_BIND) && !found_reg
                   && in_perm_reg && (count_reg != CNT_W'(N));
    // renumber inactive entries in insertion order after an unbind
    assign ren_wr   = (state_reg == ST_R2) && (in_op_reg == ACT_UNBIND)
                   && !active_reg[reb_slot_reg];
    assign last_rank = (o_reg == IDX_W'(N - 1));

    assign a_we      = bind_ins;
    assign b_we      = bind_ins || ren_wr;
    assign b_waddr   = bind_ins ? free_slot : reb_slot_reg;
    assign b_raddr   = (state_reg == ST_R1) ? rank_q : rd_idx_reg;
    assign age_we    = bind_ins || (state_reg == ST_R2);
    assign age_waddr = bind_ins ? free_slot : reb_slot_reg;
    assign age_wdata = bind_ins ? count_reg[IDX_W-1:0] : r_reg;
    // rank map: insertion rank to slot, rewritten on every walk
    assign rank_we   = (state_reg == ST_SCAN) && cmp_valid_reg
                    && used_reg[cmp_idx_reg] && !kill;

    // peer address halves and port
    rcbt_ram #(.WIDTH(PEER_W), .DEPTH(N)) u_peer_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (free_slot),
        .wdata ({in_port_reg, in_lo_reg, in_hi_reg}),
        .raddr (rd_idx_reg),
        .rdata (a_q)
    );

    // channel number as offset from the first number
    rcbt_ram #(.WIDTH(OFF_W), .DEPTH(N)) u_chan_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (free_num),
        .raddr (b_raddr),
        .rdata (b_q)
    );

    // insertion rank of each slot
    rcbt_ram #(.WIDTH(IDX_W), .DEPTH(N)) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .raddr (rd_idx_reg),
        .rdata (age_q)
    );

    rcbt_ram #(.WIDTH(IDX_W), .DEPTH(N)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (age_q),
        .wdata (cmp_idx_reg),
        .raddr (o_reg),
        .rdata (rank_q)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if ((action_t'(s_tuser) == ACT_CLEAR) || (s_tuser == 3'd7))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!issuing_reg && !cmp_valid_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (((in_op_reg == ACT_UNBIND) || (in_op_reg == ACT_DROP_ADDR)) && any_kill_reg)
                begin
                    state_next = ST_R0;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_R0:
            begin
                if (agebits_reg[o_reg])
                begin
                    state_next = ST_R1;
                end
                else if (last_rank)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_R1:
            begin
                state_next = ST_R2;
            end
            ST_R2:
            begin
                state_next = last_rank ? ST_FIN : ST_R0;
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            active_reg    <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            issuing_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        in_op_reg    <= action_t'(s_tuser);
                        in_hi_reg    <= s_tdata[63:0];
                        in_lo_reg    <= s_tdata[127:64];
                        in_port_reg  <= s_tdata[143:128];
                        in_chan_reg  <= s_tdata[158:144];
                        in_perm_reg  <= s_tdata[159];
                        found_reg    <= 1'b0;
                        any_kill_reg <= 1'b0;
                        kill_cnt_reg <= '0;
                        agebits_reg  <= '0;
                        rd_idx_reg   <= '0;
                        issuing_reg  <= 1'b1;
                        cmp_valid_reg <= 1'b0;
                        res_status_reg <= STAT_MISS;
                        res_chan_reg <= '0;
                        res_hi_reg   <= '0;
                        res_lo_reg   <= '0;
                        res_port_reg <= '0;
                        res_act_reg  <= 1'b0;
                        if (action_t'(s_tuser) == ACT_CLEAR)
                        begin
                            used_reg       <= '0;
                            active_reg     <= '0;
                            held_reg       <= '0;
                            count_reg      <= '0;
                            issuing_reg    <= 1'b0;
                            res_status_reg <= STAT_OK;
                        end
                        else if (s_tuser == 3'd7)
                        begin
                            issuing_reg <= 1'b0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (issuing_reg)
                    begin
                        cmp_valid_reg <= 1'b1;
                        cmp_idx_reg   <= rd_idx_reg;
                        if (rd_idx_reg == IDX_W'(N - 1))
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b0;
                    end
                    if (cmp_valid_reg)
                    begin
                        // first matching slot wins
                        if (is_lookup && sel_hit && !found_reg)
                        begin
                            found_reg  <= 1'b1;
                            m_slot_reg <= cmp_idx_reg;
                            m_off_reg  <= b_q;
                            m_act_reg  <= active_reg[cmp_idx_reg];
                            m_hi_reg   <= a_q[ADDR_W-1:0];
                            m_lo_reg   <= a_q[2*ADDR_W-1:ADDR_W];
                            m_port_reg <= a_q[PEER_W-1:2*ADDR_W];
                        end
                        if (kill)
                        begin
                            used_reg[cmp_idx_reg]   <= 1'b0;
                            active_reg[cmp_idx_reg] <= 1'b0;
                            held_reg[b_q]           <= 1'b0;
                            any_kill_reg            <= 1'b1;
                            kill_cnt_reg            <= kill_cnt_reg + 1'b1;
                        end
                        else if (used_reg[cmp_idx_reg])
                        begin
                            agebits_reg[age_q] <= 1'b1;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    o_reg <= '0;
                    r_reg <= '0;
                    case (in_op_reg)
                        ACT_BIND:
                        begin
                            if (found_reg)
                            begin
                                res_status_reg <= STAT_ALREADY;
                                res_chan_reg   <= chan_of(m_off_reg);
                                res_act_reg    <= m_act_reg;
                            end
                            else if (!in_perm_reg)
                            begin
                                res_status_reg <= STAT_NO_PERM;
                            end
                            else if (count_reg == CNT_W'(N))
                            begin
                                res_status_reg <= STAT_FULL;
                            end
                            else
                            begin
                                used_reg[free_slot]   <= 1'b1;
                                active_reg[free_slot] <= 1'b0;
                                held_reg[free_num]    <= 1'b1;
                                count_reg             <= count_reg + 1'b1;
                                res_status_reg        <= STAT_OK;
                                res_chan_reg          <= chan_of(free_num);
                            end
                        end
                        ACT_ACTIVATE:
                        begin
                            if (found_reg)
                            begin
                                active_reg[m_slot_reg] <= 1'b1;
                                res_status_reg <= STAT_OK;
                                res_chan_reg   <= chan_of(m_off_reg);
                                res_act_reg    <= 1'b1;
                            end
                        end
                        ACT_FIND_NUM:
                        begin
                            if (found_reg && m_act_reg)
                            begin
                                res_status_reg <= STAT_OK;
                                res_chan_reg   <= chan_of(m_off_reg);
                                res_act_reg    <= 1'b1;
                            end
                        end
                        ACT_FIND_PEER:
                        begin
                            if (found_reg)
                            begin
                                res_status_reg <= STAT_OK;
                                res_chan_reg   <= in_chan_reg;
                                res_hi_reg     <= m_hi_reg;
                                res_lo_reg     <= m_lo_reg;
                                res_port_reg   <= m_port_reg;
                                res_act_reg    <= m_act_reg;
                            end
                        end
                        ACT_UNBIND, ACT_DROP_ADDR:
                        begin
                            count_reg <= count_reg - kill_cnt_reg;
                            if (any_kill_reg)
                            begin
                                res_status_reg <= STAT_OK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_R0:
                begin
                    if (!agebits_reg[o_reg] && !last_rank)
                    begin
                        o_reg <= o_reg + 1'b1;
                    end
                end
                ST_R1:
                begin
                    reb_slot_reg <= rank_q;
                end
                ST_R2:
                begin
                    r_reg <= r_reg + 1'b1;
                    if (!last_rank)
                    begin
                        o_reg <= o_reg + 1'b1;
                    end
                    if (ren_wr)
                    begin
                        // new number taken while the old one still counts as held
                        held_reg[free_num] <= 1'b1;
                        held_reg[b_q]      <= 1'b0;
                    end
                end
                ST_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_chan_reg   <= res_chan_reg;
                        out_hi_reg     <= res_hi_reg;
                        out_lo_reg     <= res_lo_reg;
                        out_port_reg   <= res_port_reg;
                        out_act_reg    <= res_act_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_act_reg, out_port_reg, out_lo_reg, out_hi_reg, out_chan_reg};

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(N))
        else $error("entry count above table size");

    a_count_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(used_reg) == int'(count_reg)))
        else $error("entry count out of step with used flags");

    a_count_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(held_reg) == int'(count_reg)))
        else $error("held numbers out of step with entry count");

    a_active_used: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg & ~used_reg) == '0)
        else $error("active flag on an empty slot");
`endif

endmodule
